// File: rtl/core/bfre_pkg.sv
// Shared constants, codes and types of the Bellman-Ford relaxation engine.
`timescale 1ns / 1ps

package bfre_pkg;

   localparam int MAX_NODES = 1024;
   localparam int MAX_EDGES = 4096;

   localparam int NODE_W    = 10;
   localparam int NODE_AW   = $clog2(MAX_NODES);
   localparam int EDGE_AW   = $clog2(MAX_EDGES);
   localparam int ECNT_W    = $clog2(MAX_EDGES + 1);
   localparam int EIDX_W    = 12;
   localparam int DIST_W    = 32;
   localparam int SUM_W     = DIST_W + 1;
   localparam int WT_W      = 8;
   localparam int CMD_W     = 3;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = 10;

   localparam logic signed [DIST_W-1:0] DIST_INF = 32'sh7fff_ffff;
   localparam logic signed [DIST_W-1:0] DIST_MAX = 32'sh7fff_fffe;
   localparam logic signed [DIST_W-1:0] DIST_MIN = 32'sh8000_0000;

   typedef enum logic [CMD_W-1:0] {
      CMD_APPEND     = 3'd0,
      CMD_CLEAR      = 3'd1,
      CMD_RESET_DIST = 3'd2,
      CMD_RELAX      = 3'd3,
      CMD_READ       = 3'd4,
      CMD_SET_ACTIVE = 3'd5
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_NODE = 2'd0,
      CSR_END_NODE   = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic [NODE_W-1:0]      src;
      logic [NODE_W-1:0]      dst;
      logic signed [WT_W-1:0] wt;
      logic                   act;
   } edge_entry_type;

   typedef struct packed {
      logic                     pvalid;
      logic [NODE_W-1:0]        parent;
      logic signed [DIST_W-1:0] distance;
   } node_entry_type;

   localparam int EDGE_ENTRY_W = $bits(edge_entry_type);
   localparam int NODE_ENTRY_W = $bits(node_entry_type);

   typedef struct packed {
      logic [CMD_W-1:0]       command;
      logic [EIDX_W-1:0]      edge_index;
      logic [NODE_W-1:0]      from_node;
      logic [NODE_W-1:0]      to_node;
      logic signed [WT_W-1:0] edge_weight;
      logic                   edge_active;
      logic [NODE_W-1:0]      node_index;
   } req_item_type;

   typedef struct packed {
      logic                 we;
      logic [EDGE_AW-1:0]   waddr;
      edge_entry_type       wdata;
      logic                 re;
      logic [EDGE_AW-1:0]   raddr;
   } edge_ram_ctl_type;

   typedef struct packed {
      logic                 we;
      logic [NODE_AW-1:0]   waddr;
      node_entry_type       wdata;
      logic                 re;
      logic [NODE_AW-1:0]   raddr;
   } node_ram_ctl_type;

   typedef struct packed {
      logic signed [DIST_W-1:0] node_dist;
      logic signed [WT_W-1:0]   weight;
      logic signed [DIST_W-1:0] sum_held;
   } alu_in_type;

   typedef struct packed {
      logic signed [DIST_W-1:0] sum_sat;
      logic                     less;
   } alu_out_type;

endpackage

// File: rtl/core/bfre_ifs.sv
// Request, response and register-write channel interfaces of the engine.
`timescale 1ns / 1ps

interface bfre_req_if;
   import bfre_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CMD_W-1:0]       command;
   logic [EIDX_W-1:0]      edge_index;
   logic [NODE_W-1:0]      from_node;
   logic [NODE_W-1:0]      to_node;
   logic signed [WT_W-1:0] edge_weight;
   logic                   edge_active;
   logic [NODE_W-1:0]      node_index;
   modport source (output valid, command, edge_index, from_node, to_node, edge_weight,
                   edge_active, node_index, input ready);
   modport sink (input valid, command, edge_index, from_node, to_node, edge_weight,
                 edge_active, node_index, output ready);
endinterface

interface bfre_rsp_if;
   import bfre_pkg::*;
   logic                     valid;
   logic                     ready;
   logic                     changed;
   logic signed [DIST_W-1:0] node_distance;
   logic [NODE_W-1:0]        node_parent;
   logic                     parent_valid;
   logic [ECNT_W-1:0]        edge_total;
   logic                     error;
   modport source (output valid, changed, node_distance, node_parent, parent_valid,
                   edge_total, error, input ready);
   modport sink (input valid, changed, node_distance, node_parent, parent_valid,
                 edge_total, error, output ready);
endinterface

interface bfre_csr_if;
   import bfre_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_W-1:0]     data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/bfre_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bfre_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// File: rtl/core/bfre_alu.sv
// Shared saturating adder and signed comparator used by the relaxation sequence.
`timescale 1ns / 1ps

module bfre_alu (
   input  bfre_pkg::alu_in_type  alu_in,
   output bfre_pkg::alu_out_type alu_out
);
   import bfre_pkg::*;

   logic signed [SUM_W-1:0] sum_wide;
   logic signed [SUM_W-1:0] hi_lim;
   logic signed [SUM_W-1:0] lo_lim;

   assign hi_lim   = SUM_W'(DIST_MAX);
   assign lo_lim   = SUM_W'(DIST_MIN);
   assign sum_wide = SUM_W'(alu_in.node_dist) + SUM_W'(alu_in.weight);

   always_comb begin
      if (sum_wide > hi_lim) begin
         alu_out.sum_sat = DIST_MAX;
      end else if (sum_wide < lo_lim) begin
         alu_out.sum_sat = DIST_MIN;
      end else begin
         alu_out.sum_sat = sum_wide[DIST_W-1:0];
      end
      alu_out.less = (alu_in.sum_held < alu_in.node_dist);
   end
endmodule

// File: rtl/core/bfre_ctrl.sv
// Command sequencer: edge walk, node clearing, table access and the response register.
`timescale 1ns / 1ps

module bfre_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   bfre_req_if.sink                   req_ch,
   bfre_rsp_if.source                 rsp_ch,
   input  logic [bfre_pkg::NODE_W-1:0] start_node,
   input  logic [bfre_pkg::NODE_W-1:0] end_node,
   output bfre_pkg::edge_ram_ctl_type edge_ctl,
   input  bfre_pkg::edge_entry_type   edge_rd,
   output bfre_pkg::node_ram_ctl_type node_ctl,
   input  bfre_pkg::node_entry_type   node_rd,
   output bfre_pkg::alu_in_type       alu_in,
   input  bfre_pkg::alu_out_type      alu_out
);
   import bfre_pkg::*;

   typedef enum logic [10:0] {
      S_CLEAR  = 11'b000_0000_0001,
      S_IDLE   = 11'b000_0000_0010,
      S_DECODE = 11'b000_0000_0100,
      S_READ   = 11'b000_0000_1000,
      S_SETWR  = 11'b000_0001_0000,
      S_EDGE   = 11'b000_0010_0000,
      S_SRC    = 11'b000_0100_0000,
      S_DST    = 11'b000_1000_0000,
      S_CMP    = 11'b001_0000_0000,
      S_DONE   = 11'b010_0000_0000,
      S_SPARE  = 11'b100_0000_0000
   } state_type;

   state_type                state_ff, state_in;
   req_item_type             item_ff, item_in;
   logic [ECNT_W-1:0]        ecnt_ff, ecnt_in;
   logic [ECNT_W-1:0]        idx_ff, idx_in;
   logic [NODE_AW-1:0]       nidx_ff, nidx_in;
   logic [NODE_W-1:0]        clr_start_ff, clr_start_in;
   logic                     clr_reply_ff, clr_reply_in;
   logic signed [DIST_W-1:0] sum_ff, sum_in;
   logic                     res_changed_ff, res_changed_in;
   logic                     res_err_ff, res_err_in;
   node_entry_type           res_node_ff, res_node_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_changed_ff, rsp_changed_in;
   logic signed [DIST_W-1:0] rsp_dist_ff, rsp_dist_in;
   logic [NODE_W-1:0]        rsp_parent_ff, rsp_parent_in;
   logic                     rsp_pvalid_ff, rsp_pvalid_in;
   logic [ECNT_W-1:0]        rsp_total_ff, rsp_total_in;
   logic                     rsp_err_ff, rsp_err_in;
   logic                     edge_skip;
   logic                     node_in_range;

   assign alu_in.node_dist = node_rd.distance;
   assign alu_in.weight    = edge_rd.wt;
   assign alu_in.sum_held  = sum_ff;

   assign req_ch.ready = (state_ff == S_IDLE);

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.changed       = rsp_changed_ff;
   assign rsp_ch.node_distance = rsp_dist_ff;
   assign rsp_ch.node_parent   = rsp_parent_ff;
   assign rsp_ch.parent_valid  = rsp_pvalid_ff;
   assign rsp_ch.edge_total    = rsp_total_ff;
   assign rsp_ch.error         = rsp_err_ff;

   assign edge_skip = !edge_rd.act
                      || ((NODE_W + 1)'(edge_rd.src) >= (NODE_W + 1)'(MAX_NODES))
                      || ((NODE_W + 1)'(edge_rd.dst) >= (NODE_W + 1)'(MAX_NODES))
                      || (edge_rd.dst == start_node)
                      || (edge_rd.src == end_node);

   assign node_in_range = ((NODE_W + 1)'(item_ff.node_index) < (NODE_W + 1)'(MAX_NODES));

   always_comb begin
      state_in       = state_ff;
      item_in        = item_ff;
      ecnt_in        = ecnt_ff;
      idx_in         = idx_ff;
      nidx_in        = nidx_ff;
      clr_start_in   = clr_start_ff;
      clr_reply_in   = clr_reply_ff;
      sum_in         = sum_ff;
      res_changed_in = res_changed_ff;
      res_err_in     = res_err_ff;
      res_node_in    = res_node_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_changed_in = rsp_changed_ff;
      rsp_dist_in    = rsp_dist_ff;
      rsp_parent_in  = rsp_parent_ff;
      rsp_pvalid_in  = rsp_pvalid_ff;
      rsp_total_in   = rsp_total_ff;
      rsp_err_in     = rsp_err_ff;
      edge_ctl       = '0;
      node_ctl       = '0;

      unique case (state_ff)
         S_CLEAR: begin
            node_ctl.we             = 1'b1;
            node_ctl.waddr          = nidx_ff;
            node_ctl.wdata.pvalid   = 1'b0;
            node_ctl.wdata.parent   = '0;
            node_ctl.wdata.distance = (nidx_ff == NODE_AW'(clr_start_ff)) ? '0 : DIST_INF;
            if (nidx_ff == NODE_AW'(MAX_NODES - 1)) begin
               state_in = clr_reply_ff ? S_DONE : S_IDLE;
            end else begin
               nidx_in = nidx_ff + NODE_AW'(1);
            end
         end
         S_IDLE: begin
            if (req_ch.valid) begin
               item_in.command     = req_ch.command;
               item_in.edge_index  = req_ch.edge_index;
               item_in.from_node   = req_ch.from_node;
               item_in.to_node     = req_ch.to_node;
               item_in.edge_weight = req_ch.edge_weight;
               item_in.edge_active = req_ch.edge_active;
               item_in.node_index  = req_ch.node_index;
               res_changed_in      = 1'b0;
               res_err_in          = 1'b0;
               res_node_in         = '0;
               state_in            = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (cmd_type'(item_ff.command))
               CMD_APPEND: begin
                  if (ecnt_ff < ECNT_W'(MAX_EDGES)) begin
                     edge_ctl.we        = 1'b1;
                     edge_ctl.waddr     = ecnt_ff[EDGE_AW-1:0];
                     edge_ctl.wdata.src = item_ff.from_node;
                     edge_ctl.wdata.dst = item_ff.to_node;
                     edge_ctl.wdata.wt  = item_ff.edge_weight;
                     edge_ctl.wdata.act = item_ff.edge_active;
                     ecnt_in            = ecnt_ff + ECNT_W'(1);
                  end else begin
                     res_err_in = 1'b1;
                  end
                  state_in = S_DONE;
               end
               CMD_CLEAR: begin
                  ecnt_in  = '0;
                  state_in = S_DONE;
               end
               CMD_RESET_DIST: begin
                  clr_start_in = start_node;
                  clr_reply_in = 1'b1;
                  nidx_in      = '0;
                  state_in     = S_CLEAR;
               end
               CMD_RELAX: begin
                  idx_in   = '0;
                  state_in = S_EDGE;
               end
               CMD_READ: begin
                  if (node_in_range) begin
                     node_ctl.re    = 1'b1;
                     node_ctl.raddr = NODE_AW'(item_ff.node_index);
                     state_in       = S_READ;
                  end else begin
                     res_node_in.distance = DIST_INF;
                     res_err_in           = 1'b1;
                     state_in             = S_DONE;
                  end
               end
               CMD_SET_ACTIVE: begin
                  if (ECNT_W'(item_ff.edge_index) < ecnt_ff) begin
                     edge_ctl.re    = 1'b1;
                     edge_ctl.raddr = EDGE_AW'(item_ff.edge_index);
                     state_in       = S_SETWR;
                  end else begin
                     res_err_in = 1'b1;
                     state_in   = S_DONE;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_READ: begin
            res_node_in = node_rd;
            state_in    = S_DONE;
         end
         S_SETWR: begin
            edge_ctl.we        = 1'b1;
            edge_ctl.waddr     = EDGE_AW'(item_ff.edge_index);
            edge_ctl.wdata     = edge_rd;
            edge_ctl.wdata.act = item_ff.edge_active;
            state_in           = S_DONE;
         end
         S_EDGE: begin
            if (idx_ff < ecnt_ff) begin
               edge_ctl.re    = 1'b1;
               edge_ctl.raddr = idx_ff[EDGE_AW-1:0];
               state_in       = S_SRC;
            end else begin
               state_in = S_DONE;
            end
         end
         S_SRC: begin
            if (edge_skip) begin
               idx_in   = idx_ff + ECNT_W'(1);
               state_in = S_EDGE;
            end else begin
               node_ctl.re    = 1'b1;
               node_ctl.raddr = NODE_AW'(edge_rd.src);
               state_in       = S_DST;
            end
         end
         S_DST: begin
            if (node_rd.distance == DIST_INF) begin
               idx_in   = idx_ff + ECNT_W'(1);
               state_in = S_EDGE;
            end else begin
               sum_in         = alu_out.sum_sat;
               node_ctl.re    = 1'b1;
               node_ctl.raddr = NODE_AW'(edge_rd.dst);
               state_in       = S_CMP;
            end
         end
         S_CMP: begin
            if (alu_out.less) begin
               node_ctl.we             = 1'b1;
               node_ctl.waddr          = NODE_AW'(edge_rd.dst);
               node_ctl.wdata.pvalid   = 1'b1;
               node_ctl.wdata.parent   = edge_rd.src;
               node_ctl.wdata.distance = sum_ff;
               res_changed_in          = 1'b1;
            end
            idx_in   = idx_ff + ECNT_W'(1);
            state_in = S_EDGE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_changed_in = res_changed_ff;
               rsp_dist_in    = res_node_ff.distance;
               rsp_parent_in  = res_node_ff.pvalid ? res_node_ff.parent : '0;
               rsp_pvalid_in  = res_node_ff.pvalid;
               rsp_total_in   = ecnt_ff;
               rsp_err_in     = res_err_ff;
               clr_reply_in   = 1'b0;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         ecnt_ff      <= '0;
         nidx_ff      <= '0;
         clr_start_ff <= '0;
         clr_reply_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ecnt_ff      <= ecnt_in;
         nidx_ff      <= nidx_in;
         clr_start_ff <= clr_start_in;
         clr_reply_ff <= clr_reply_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff        <= item_in;
      idx_ff         <= idx_in;
      sum_ff         <= sum_in;
      res_changed_ff <= res_changed_in;
      res_err_ff     <= res_err_in;
      res_node_ff    <= res_node_in;
      rsp_changed_ff <= rsp_changed_in;
      rsp_dist_ff    <= rsp_dist_in;
      rsp_parent_ff  <= rsp_parent_in;
      rsp_pvalid_ff  <= rsp_pvalid_in;
      rsp_total_ff   <= rsp_total_in;
      rsp_err_ff     <= rsp_err_in;
   end
endmodule

// File: rtl/core/bellman_ford_relax_engine.sv
// Top level of the Bellman-Ford relaxation engine: registers, tables and sequencer.
//
//   Channel   Direction   Handshake       Carries
//   req_ch    in          valid / ready   one command item with its operands
//   rsp_ch    out         valid / ready   one result item per command
//   csr_ch    in          valid / ready   register index and write data
//
// Append, clear and unused codes go from decode to the result; read node and set
// active add a table access. Reset distances writes one node entry per cycle.
// A relax pass reads each edge, then its source and destination entries in turn
// through the single node table read port; a skipped edge or unreached source ends early.
// After reset the node table is cleared while req_ch is not ready.
// A finished result waits in the output register; the next item is taken meanwhile.
`timescale 1ns / 1ps

module bellman_ford_relax_engine (
   input  logic       clock,
   input  logic       reset,
   bfre_req_if.sink   req_ch,
   bfre_rsp_if.source rsp_ch,
   bfre_csr_if.sink   csr_ch
);
   import bfre_pkg::*;

   logic [NODE_W-1:0] start_node_ff, start_node_in;
   logic [NODE_W-1:0] end_node_ff, end_node_in;
   edge_ram_ctl_type  edge_ctl;
   node_ram_ctl_type  node_ctl;
   logic [EDGE_ENTRY_W-1:0] edge_rdata;
   logic [NODE_ENTRY_W-1:0] node_rdata;
   alu_in_type        alu_in;
   alu_out_type       alu_out;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      start_node_in = start_node_ff;
      end_node_in   = end_node_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_START_NODE: start_node_in = NODE_W'(csr_ch.data);
            CSR_END_NODE:   end_node_in   = NODE_W'(csr_ch.data);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_node_ff <= NODE_W'(0);
         end_node_ff   <= NODE_W'(1);
      end else begin
         start_node_ff <= start_node_in;
         end_node_ff   <= end_node_in;
      end
   end

   bfre_ram #(
      .WIDTH (EDGE_ENTRY_W),
      .DEPTH (MAX_EDGES)
   ) u_edge_ram (
      .clock (clock),
      .we    (edge_ctl.we),
      .waddr (edge_ctl.waddr),
      .wdata (edge_ctl.wdata),
      .re    (edge_ctl.re),
      .raddr (edge_ctl.raddr),
      .rdata (edge_rdata)
   );

   bfre_ram #(
      .WIDTH (NODE_ENTRY_W),
      .DEPTH (MAX_NODES)
   ) u_node_ram (
      .clock (clock),
      .we    (node_ctl.we),
      .waddr (node_ctl.waddr),
      .wdata (node_ctl.wdata),
      .re    (node_ctl.re),
      .raddr (node_ctl.raddr),
      .rdata (node_rdata)
   );

   bfre_alu u_alu (
      .alu_in  (alu_in),
      .alu_out (alu_out)
   );

   bfre_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .start_node (start_node_ff),
      .end_node   (end_node_ff),
      .edge_ctl   (edge_ctl),
      .edge_rd    (edge_entry_type'(edge_rdata)),
      .node_ctl   (node_ctl),
      .node_rd    (node_entry_type'(node_rdata)),
      .alu_in     (alu_in),
      .alu_out    (alu_out)
   );
endmodule

// File: rtl/core/bfre_checker.sv
// Port-level assertions for the relaxation engine and their bind to the top level.
`timescale 1ns / 1ps

module bfre_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic                              rsp_changed,
   input logic signed [bfre_pkg::DIST_W-1:0] rsp_node_distance,
   input logic                              rsp_parent_valid,
   input logic [bfre_pkg::ECNT_W-1:0]       rsp_edge_total,
   input logic                              rsp_error
);
   import bfre_pkg::*;

   a_clear_after_reset: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("request side ready while the node table is being cleared");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response item dropped before it was taken");

   a_changed_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_changed |-> rsp_node_distance == '0 && !rsp_parent_valid && !rsp_error)
      else $error("relax result carries node or error fields");

   a_parent_reached: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_parent_valid |-> rsp_node_distance != DIST_INF)
      else $error("node with a parent reported at infinite distance");

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_edge_total <= ECNT_W'(MAX_EDGES))
      else $error("edge count beyond table size");
endmodule

bind bellman_ford_relax_engine bfre_checker u_bfre_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_changed       (rsp_ch.changed),
   .rsp_node_distance (rsp_ch.node_distance),
   .rsp_parent_valid  (rsp_ch.parent_valid),
   .rsp_edge_total    (rsp_ch.edge_total),
   .rsp_error         (rsp_ch.error)
);
